/* design/rfcd_pkg.sv */
// Shared types and constants for the reply frame completion detector.
`default_nettype none
package rfcd_pkg;

    localparam int LENGTH_BITS_DEF = 31;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LINE,
        PH_HEADER,
        PH_BODY,
        PH_ELEM_TYPE,
        PH_DONE
    } phase_t;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_SIMPLE  = 3'd1;
    localparam logic [2:0] KIND_ERROR   = 3'd2;
    localparam logic [2:0] KIND_INTEGER = 3'd3;
    localparam logic [2:0] KIND_BULK    = 3'd4;
    localparam logic [2:0] KIND_ARRAY   = 3'd5;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

endpackage
`default_nettype wire

/* design/reply_frame_completion_detector.sv */
// Top level: byte-wide reply framer reporting completion and malformed status.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | [7:0] data_byte                         | [0] start_of_reply
//  m_      | out | [0] complete [1] malformed [4:2] kind   | -
//
// One result transaction per input transaction. Each byte goes through an input
// register, then one pass of parse logic into the result register (the decimal
// accumulator and the body counter set the path). One byte per cycle sustained
// while the result is not stalled. Synchronous active-low reset clears parse
// state and both valid flags. A stalled result holds; the input register still
// takes a byte while the result register is free or being drained.
`default_nettype none
module reply_frame_completion_detector #(
    parameter int LENGTH_BITS = rfcd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [0:0] s_tuser,   // [0] start_of_reply
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] complete, [1] malformed, [4:2] reply_kind
);

    localparam int LB = LENGTH_BITS;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // result stage
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic [7:0] out_data_next;

    logic advance;

    // parse state
    rfcd_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic          cr_reg, cr_next, cur_cr;
    logic [LB-1:0] hv_reg, hv_next, cur_hv;
    logic          neg_reg, neg_next, cur_neg;
    logic          hasd_reg, hasd_next, cur_hasd;
    logic          closed_reg, closed_next, cur_closed;
    logic          sign_reg, sign_next, cur_sign;
    logic [LB:0]   body_reg, body_next, cur_body;
    logic [LB-1:0] el_reg, el_next, cur_el;
    logic          inside_reg, inside_next, cur_inside;
    logic [2:0]    kind_reg, kind_next, cur_kind;
    logic          comp_reg, comp_next, cur_comp;
    logic          malf_reg, malf_next, cur_malf;

    logic          is_digit;
    logic          is_space;
    logic          line_end;
    logic [LB+3:0] prod;
    logic          ovf;
    logic [LB-1:0] el_dec;
    logic [LB:0]   body_dec;
    logic          seg_end;
    logic          open_seg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= rfcd_pkg::PH_TYPE;
            cr_reg     <= 1'b0;
            hv_reg     <= '0;
            neg_reg    <= 1'b0;
            hasd_reg   <= 1'b0;
            closed_reg <= 1'b0;
            sign_reg   <= 1'b0;
            body_reg   <= '0;
            el_reg     <= '0;
            inside_reg <= 1'b0;
            kind_reg   <= rfcd_pkg::KIND_NONE;
            comp_reg   <= 1'b0;
            malf_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            cr_reg     <= cr_next;
            hv_reg     <= hv_next;
            neg_reg    <= neg_next;
            hasd_reg   <= hasd_next;
            closed_reg <= closed_next;
            sign_reg   <= sign_next;
            body_reg   <= body_next;
            el_reg     <= el_next;
            inside_reg <= inside_next;
            kind_reg   <= kind_next;
            comp_reg   <= comp_next;
            malf_reg   <= malf_next;
        end
    end

    // start of reply replaces the stored state with the reset state
    always_comb begin
        if (in_start_reg) begin
            cur_phase  = rfcd_pkg::PH_TYPE;
            cur_cr     = 1'b0;
            cur_hv     = '0;
            cur_neg    = 1'b0;
            cur_hasd   = 1'b0;
            cur_closed = 1'b0;
            cur_sign   = 1'b0;
            cur_body   = '0;
            cur_el     = '0;
            cur_inside = 1'b0;
            cur_kind   = rfcd_pkg::KIND_NONE;
            cur_comp   = 1'b0;
            cur_malf   = 1'b0;
        end else begin
            cur_phase  = phase_reg;
            cur_cr     = cr_reg;
            cur_hv     = hv_reg;
            cur_neg    = neg_reg;
            cur_hasd   = hasd_reg;
            cur_closed = closed_reg;
            cur_sign   = sign_reg;
            cur_body   = body_reg;
            cur_el     = el_reg;
            cur_inside = inside_reg;
            cur_kind   = kind_reg;
            cur_comp   = comp_reg;
            cur_malf   = malf_reg;
        end
    end

    assign is_digit = (in_byte_reg >= rfcd_pkg::CH_ZERO) && (in_byte_reg <= rfcd_pkg::CH_NINE);
    assign is_space = (in_byte_reg == rfcd_pkg::CH_SPACE)
                   || ((in_byte_reg >= rfcd_pkg::CH_TAB) && (in_byte_reg <= rfcd_pkg::CH_CR));
    assign line_end = cur_cr && (in_byte_reg == rfcd_pkg::CH_LF);
    // value * 10 + digit
    assign prod     = {1'b0, cur_hv, 3'b000} + {3'b000, cur_hv, 1'b0}
                    + {{LB{1'b0}}, in_byte_reg[3:0]};
    assign ovf      = |prod[LB+3:LB];
    assign el_dec   = cur_el - {{(LB-1){1'b0}}, 1'b1};
    assign body_dec = cur_body - {{LB{1'b0}}, 1'b1};

    always_comb begin
        phase_next  = cur_phase;
        cr_next     = cur_cr;
        hv_next     = cur_hv;
        neg_next    = cur_neg;
        hasd_next   = cur_hasd;
        closed_next = cur_closed;
        sign_next   = cur_sign;
        body_next   = cur_body;
        el_next     = cur_el;
        inside_next = cur_inside;
        kind_next   = cur_kind;
        comp_next   = cur_comp;
        malf_next   = cur_malf;
        seg_end     = 1'b0;
        open_seg    = 1'b0;

        unique case (cur_phase)
            rfcd_pkg::PH_TYPE: begin
                case (in_byte_reg)
                    rfcd_pkg::CH_PLUS:   kind_next = rfcd_pkg::KIND_SIMPLE;
                    rfcd_pkg::CH_MINUS:  kind_next = rfcd_pkg::KIND_ERROR;
                    rfcd_pkg::CH_COLON:  kind_next = rfcd_pkg::KIND_INTEGER;
                    rfcd_pkg::CH_DOLLAR: kind_next = rfcd_pkg::KIND_BULK;
                    rfcd_pkg::CH_STAR:   kind_next = rfcd_pkg::KIND_ARRAY;
                    default:             kind_next = rfcd_pkg::KIND_NONE;
                endcase
                if (kind_next == rfcd_pkg::KIND_NONE) begin
                    malf_next  = 1'b1;
                    phase_next = rfcd_pkg::PH_DONE;
                end else if (kind_next >= rfcd_pkg::KIND_BULK) begin
                    open_seg   = 1'b1;
                    phase_next = rfcd_pkg::PH_HEADER;
                end else begin
                    open_seg   = 1'b1;
                    phase_next = rfcd_pkg::PH_LINE;
                end
            end
            rfcd_pkg::PH_ELEM_TYPE: begin
                case (in_byte_reg) inside
                    rfcd_pkg::CH_PLUS, rfcd_pkg::CH_MINUS, rfcd_pkg::CH_COLON: begin
                        open_seg   = 1'b1;
                        phase_next = rfcd_pkg::PH_LINE;
                    end
                    rfcd_pkg::CH_DOLLAR: begin
                        open_seg   = 1'b1;
                        phase_next = rfcd_pkg::PH_HEADER;
                    end
                    rfcd_pkg::CH_STAR: begin
                        comp_next  = 1'b1;
                        phase_next = rfcd_pkg::PH_DONE;
                    end
                    default: begin
                        malf_next  = 1'b1;
                        phase_next = rfcd_pkg::PH_DONE;
                    end
                endcase
            end
            rfcd_pkg::PH_LINE: begin
                if (line_end) begin
                    seg_end = 1'b1;
                end else begin
                    cr_next = (in_byte_reg == rfcd_pkg::CH_CR);
                end
            end
            rfcd_pkg::PH_HEADER: begin
                if (line_end) begin
                    if (!cur_hasd) begin
                        malf_next  = 1'b1;
                        phase_next = rfcd_pkg::PH_DONE;
                    end else if (!cur_inside && (cur_kind == rfcd_pkg::KIND_ARRAY)) begin
                        if (cur_neg || (cur_hv == '0)) begin
                            comp_next  = 1'b1;
                            phase_next = rfcd_pkg::PH_DONE;
                        end else begin
                            el_next     = cur_hv;
                            inside_next = 1'b1;
                            open_seg    = 1'b1;
                            phase_next  = rfcd_pkg::PH_ELEM_TYPE;
                        end
                    end else if (cur_neg && (cur_hv != '0)) begin
                        seg_end = 1'b1;
                    end else begin
                        body_next  = {1'b0, cur_hv} + {{(LB-1){1'b0}}, 2'd2};
                        phase_next = rfcd_pkg::PH_BODY;
                    end
                end else begin
                    cr_next = (in_byte_reg == rfcd_pkg::CH_CR);
                    if (!cur_closed) begin
                        if (is_digit) begin
                            if (ovf) begin
                                malf_next  = 1'b1;
                                phase_next = rfcd_pkg::PH_DONE;
                            end else begin
                                hv_next   = prod[LB-1:0];
                                hasd_next = 1'b1;
                            end
                        end else if (!cur_hasd && !cur_sign && is_space) begin
                            hasd_next = cur_hasd;
                        end else if (!cur_hasd && !cur_sign
                                     && ((in_byte_reg == rfcd_pkg::CH_PLUS)
                                      || (in_byte_reg == rfcd_pkg::CH_MINUS))) begin
                            sign_next = 1'b1;
                            neg_next  = (in_byte_reg == rfcd_pkg::CH_MINUS);
                        end else begin
                            closed_next = 1'b1;
                        end
                    end
                end
            end
            rfcd_pkg::PH_BODY: begin
                body_next = body_dec;
                if (body_dec == '0) begin
                    seg_end = 1'b1;
                end
            end
            default: begin
                phase_next = cur_phase;
            end
        endcase

        // end of a line, header or body: next element or end of reply
        if (seg_end) begin
            if (cur_inside) begin
                el_next = el_dec;
                if (el_dec == '0) begin
                    comp_next  = 1'b1;
                    phase_next = rfcd_pkg::PH_DONE;
                end else begin
                    open_seg   = 1'b1;
                    phase_next = rfcd_pkg::PH_ELEM_TYPE;
                end
            end else begin
                comp_next  = 1'b1;
                phase_next = rfcd_pkg::PH_DONE;
            end
        end

        if (open_seg) begin
            cr_next     = 1'b0;
            hv_next     = '0;
            neg_next    = 1'b0;
            hasd_next   = 1'b0;
            closed_next = 1'b0;
            sign_next   = 1'b0;
        end

        out_data_next = {3'b000, kind_next, malf_next, comp_next};
    end

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(comp_reg && malf_reg))
        else $error("complete and malformed both set");

    a_done_iff_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == rfcd_pkg::PH_DONE) == (comp_reg || malf_reg))
        else $error("done phase disagrees with status flags");

    a_inside_is_array: assert property (@(posedge aclk) disable iff (!aresetn)
        inside_reg |-> (kind_reg == rfcd_pkg::KIND_ARRAY))
        else $error("element count active outside an array reply");

    a_body_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == rfcd_pkg::PH_BODY) |-> (body_reg != '0))
        else $error("body phase with no bytes left");

    a_result_follows_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_tvalid && (m_tdata == $past(out_data_next))))
        else $error("result register missed a parse step");

endmodule
`default_nettype wire
